// File: hdl/iprle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprle_pkg: shared types and constants of the icon plane RLE encoder
// Result word format, sequencer phases, configuration indexes and defaults.
// ----------------------------------------------------------------------------
package iprle_pkg;

  // Defaults for the top-level parameters.
  localparam int MaxPixelsDef  = 16384;
  localparam int MaxLiteralDef = 128;
  localparam int MaxRunDef     = 130;

  // Shortest run that is coded as a repeat group.
  localparam int RunMin = 3;

  localparam int DataW       = 64;
  localparam int CountW      = 4;
  localparam int PixelCountW = 15;
  localparam int CfgDataW    = 15;

  localparam logic [7:0]        RunFlag     = 8'h80;
  localparam logic [CountW-1:0] PrefixBytes = 4'd4;
  localparam logic [CountW-1:0] WordBytes   = 4'd8;

  // Configuration register indexes.
  localparam logic CfgPixelCount   = 1'b0;
  localparam logic CfgPrefixEnable = 1'b1;

  // Where the sequencer stands within one input byte.
  typedef enum logic [1:0] {
    PH_MAIN,   // prefix, then run extension or closing of the previous run
    PH_CLOSE,  // closing of the previous run still in progress
    PH_END,    // plane end: closing of the last run
    PH_TAIL    // plane end: sending the pending literal block
  } phase_e;

  // One step of closing a run.
  typedef enum logic [1:0] {
    ACT_FLUSH,       // send one word of the literal block
    ACT_RUN,         // send the repeat group
    ACT_APPEND_ALL,  // move the whole short run into the literal block
    ACT_APPEND_ONE   // move one byte; the block fills up after it
  } act_e;

  typedef struct packed {
    logic [DataW-1:0]  data;
    logic [CountW-1:0] byte_count;
    logic              end_of_plane;
    logic              end_of_image;
    logic              last_of_item;
  } word_t;

endpackage

// File: hdl/iprle_lit_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprle_lit_buf: literal block store
// Holds the pending literal bytes as rows of eight, with byte 0 of row 0 kept
// free for the block header, so that a flush reads one result word per row.
// ----------------------------------------------------------------------------
module iprle_lit_buf #(
  parameter int   MaxLiteral = iprle_pkg::MaxLiteralDef,
  localparam int  LcW        = $clog2(MaxLiteral + 1),
  localparam int  Rows       = (MaxLiteral + 8) / 8,
  localparam int  RowW       = (Rows > 1) ? $clog2(Rows) : 1,
  localparam int  PosW       = $clog2(Rows * 8)
) (
  input  logic                           clk_i,
  input  logic [1:0]                     app_cnt_i,
  input  logic [7:0]                     app_value_i,
  input  logic [LcW-1:0]                 lit_count_i,
  input  logic [RowW-1:0]                rd_row_i,
  output logic [iprle_pkg::DataW-1:0]    rd_data_o,
  output logic [iprle_pkg::CountW-1:0]   rd_count_o
);

  logic [iprle_pkg::DataW-1:0] rows_q [Rows];
  logic [PosW-1:0]             pos1;
  logic [PosW-1:0]             pos2;

  // Literal byte i lives at position i + 1.
  assign pos1 = PosW'(lit_count_i) + PosW'(1);
  assign pos2 = pos1 + PosW'(1);

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < Rows; r++) begin
      for (int l = 0; l < 8; l++) begin
        if (((app_cnt_i != 2'd0) && (pos1 == PosW'(r * 8 + l))) ||
            ((app_cnt_i == 2'd2) && (pos2 == PosW'(r * 8 + l)))) begin
          rows_q[r][8*l +: 8] <= app_value_i;
        end
      end
    end
  end

  always_comb begin
    logic [iprle_pkg::DataW-1:0] row_word;
    logic [7:0]                  lc8;
    logic [RowW-1:0]             last_row;
    row_word = rows_q[rd_row_i];
    lc8      = 8'(lit_count_i);
    last_row = RowW'(lit_count_i >> 3);
    if (rd_row_i == '0) begin
      row_word[7:0] = {1'b0, lc8[6:0] - 7'd1};
    end
    if (rd_row_i == last_row) begin
      rd_count_o = {1'b0, lc8[2:0]} + 4'd1;
    end else begin
      rd_count_o = iprle_pkg::WordBytes;
    end
    // Bytes past the valid count read as zero.
    for (int l = 0; l < 8; l++) begin
      if (4'(l) >= rd_count_o) begin
        row_word[8*l +: 8] = 8'h00;
      end
    end
    rd_data_o = row_word;
  end

endmodule

// File: hdl/iprle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprle_ctrl: run and literal sequencer
// Tracks the open run, the literal block fill and the plane position, and
// decides for the held byte what is written to the store and which word goes
// out in the current cycle.
// ----------------------------------------------------------------------------
module iprle_ctrl #(
  parameter int  MaxPixels  = iprle_pkg::MaxPixelsDef,
  parameter int  MaxLiteral = iprle_pkg::MaxLiteralDef,
  parameter int  MaxRun     = iprle_pkg::MaxRunDef,
  localparam int NW         = $clog2(MaxPixels + 1),
  localparam int LcW        = $clog2(MaxLiteral + 1),
  localparam int RlW        = $clog2(MaxRun + 1),
  localparam int Rows       = (MaxLiteral + 8) / 8,
  localparam int RowW       = (Rows > 1) ? $clog2(Rows) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 item_valid_i,
  input  logic [7:0]                           sample_i,
  input  logic [iprle_pkg::PixelCountW-1:0]    pixel_count_i,
  input  logic                                 prefix_enable_i,
  input  logic                                 can_emit_i,
  output logic                                 item_done_o,
  output logic                                 emit_o,
  output iprle_pkg::word_t                     word_o,
  output logic [1:0]                           app_cnt_o,
  output logic [7:0]                           app_value_o,
  output logic [LcW-1:0]                       lit_count_o,
  output logic [RowW-1:0]                      rd_row_o,
  input  logic [iprle_pkg::DataW-1:0]          rd_data_i,
  input  logic [iprle_pkg::CountW-1:0]         rd_count_i
);

  iprle_pkg::phase_e phase_q, phase_d;
  iprle_pkg::act_e   act;

  logic [7:0]      rv_q, rv_d;
  logic [RlW-1:0]  rl_q, rl_d;
  logic [LcW-1:0]  lc_q, lc_d;
  logic [RowW-1:0] row_q, row_d;
  logic [NW-1:0]   pos_q, pos_d;
  logic [1:0]      plane_q, plane_d;
  logic            prefix_done_q, prefix_done_d;

  logic [NW-1:0]   n_eff;
  logic            eop;
  logic            ext;
  logic            run_long;
  logic            lc_full;
  logic [1:0]      rl_lo;
  logic            fits;
  logic            more_after_flush;
  logic            emits_close;
  logic            is_last_row;
  logic            need_prefix;

  logic            emit;
  logic            finish;
  logic            en;
  logic [1:0]      app_cnt;
  iprle_pkg::word_t word;

  // Effective plane size: zero acts as one, oversize is clipped.
  always_comb begin
    if (pixel_count_i == '0) begin
      n_eff = NW'(1);
    end else if (32'(pixel_count_i) > 32'(MaxPixels)) begin
      n_eff = NW'(MaxPixels);
    end else begin
      n_eff = NW'(pixel_count_i);
    end
  end

  assign eop      = ({1'b0, pos_q} + (NW + 1)'(1)) >= {1'b0, n_eff};
  assign ext      = (rl_q != '0) && (sample_i == rv_q) && (rl_q < RlW'(MaxRun));
  assign run_long = rl_q >= RlW'(iprle_pkg::RunMin);
  assign lc_full  = lc_q >= LcW'(MaxLiteral);
  assign rl_lo    = rl_q[1:0];
  assign fits     = ({1'b0, lc_q} + (LcW + 1)'(rl_lo)) <= (LcW + 1)'(MaxLiteral);
  assign more_after_flush = run_long || ((LcW + 1)'(rl_lo) > (LcW + 1)'(MaxLiteral));
  assign emits_close = run_long || !fits;
  assign is_last_row = row_q == RowW'(lc_q >> 3);
  assign need_prefix = !prefix_done_q && prefix_enable_i;

  // Next step of closing the open run.
  always_comb begin
    if (run_long) begin
      act = (lc_q != '0) ? iprle_pkg::ACT_FLUSH : iprle_pkg::ACT_RUN;
    end else if ((rl_q != '0) && lc_full) begin
      act = iprle_pkg::ACT_FLUSH;
    end else if (fits) begin
      act = iprle_pkg::ACT_APPEND_ALL;
    end else begin
      act = iprle_pkg::ACT_APPEND_ONE;
    end
  end

  always_comb begin
    logic run_step;
    logic in_end;
    logic main_done;
    logic [7:0] run_hdr;
    phase_d       = phase_q;
    rv_d          = rv_q;
    rl_d          = rl_q;
    lc_d          = lc_q;
    row_d         = row_q;
    pos_d         = pos_q;
    plane_d       = plane_q;
    prefix_done_d = prefix_done_q;
    emit          = 1'b0;
    finish        = 1'b0;
    app_cnt       = 2'd0;
    word          = '0;
    run_step      = 1'b0;
    in_end        = 1'b0;
    main_done     = 1'b0;
    run_hdr       = iprle_pkg::RunFlag |
                    {1'b0, 7'(rl_q - RlW'(iprle_pkg::RunMin))};

    case (phase_q)
      iprle_pkg::PH_MAIN: begin
        prefix_done_d = 1'b1;
        if (need_prefix) begin
          emit              = 1'b1;
          word.byte_count   = iprle_pkg::PrefixBytes;
          word.last_of_item = !eop && (ext || !emits_close);
        end else if (ext) begin
          rl_d      = rl_q + RlW'(1);
          main_done = 1'b1;
        end else begin
          run_step = 1'b1;
        end
      end
      iprle_pkg::PH_CLOSE: begin
        run_step = 1'b1;
      end
      iprle_pkg::PH_END: begin
        run_step = 1'b1;
        in_end   = 1'b1;
      end
      iprle_pkg::PH_TAIL: begin
        if (lc_q != '0) begin
          emit            = 1'b1;
          word.data       = rd_data_i;
          word.byte_count = rd_count_i;
          if (is_last_row) begin
            lc_d              = '0;
            row_d             = '0;
            word.last_of_item = 1'b1;
            word.end_of_plane = 1'b1;
            word.end_of_image = plane_q[1];
            finish            = 1'b1;
          end else begin
            row_d = row_q + RowW'(1);
          end
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_d = iprle_pkg::PH_MAIN;
      end
    endcase

    if (run_step) begin
      case (act)
        iprle_pkg::ACT_FLUSH: begin
          emit              = 1'b1;
          word.data         = rd_data_i;
          word.byte_count   = rd_count_i;
          word.last_of_item = !in_end && !eop && is_last_row && !more_after_flush;
          if (is_last_row) begin
            lc_d  = '0;
            row_d = '0;
          end else begin
            row_d = row_q + RowW'(1);
          end
          phase_d = in_end ? iprle_pkg::PH_END : iprle_pkg::PH_CLOSE;
        end
        iprle_pkg::ACT_RUN: begin
          emit            = 1'b1;
          word.data       = {48'h0, rv_q, run_hdr};
          word.byte_count = 4'd2;
          if (in_end) begin
            rl_d              = '0;
            word.last_of_item = 1'b1;
            word.end_of_plane = 1'b1;
            word.end_of_image = plane_q[1];
            finish            = 1'b1;
          end else begin
            word.last_of_item = !eop;
            main_done         = 1'b1;
          end
        end
        iprle_pkg::ACT_APPEND_ALL: begin
          app_cnt = rl_lo;
          lc_d    = lc_q + LcW'(rl_lo);
          if (in_end) begin
            rl_d    = '0;
            phase_d = iprle_pkg::PH_TAIL;
          end else begin
            main_done = 1'b1;
          end
        end
        iprle_pkg::ACT_APPEND_ONE: begin
          app_cnt = 2'd1;
          lc_d    = lc_q + LcW'(1);
          rl_d    = rl_q - RlW'(1);
          phase_d = in_end ? iprle_pkg::PH_END : iprle_pkg::PH_CLOSE;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
      // A finished close in the main part opens the new run.
      if (main_done && (phase_q != iprle_pkg::PH_MAIN || !ext)) begin
        rv_d = sample_i;
        rl_d = RlW'(1);
      end
    end

    if (main_done) begin
      if (eop) begin
        phase_d = iprle_pkg::PH_END;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      phase_d = iprle_pkg::PH_MAIN;
      if (eop) begin
        pos_d = '0;
        if (plane_q[1]) begin
          plane_d       = 2'd0;
          prefix_done_d = 1'b0;
        end else begin
          plane_d = plane_q + 2'd1;
        end
      end else begin
        pos_d = pos_q + NW'(1);
      end
    end
  end

  // The held byte advances unless its word cannot be taken this cycle.
  assign en          = item_valid_i && (!emit || can_emit_i);
  assign emit_o      = en && emit;
  assign item_done_o = en && finish;
  assign word_o      = word;
  assign app_cnt_o   = en ? app_cnt : 2'd0;
  assign app_value_o = rv_q;
  assign lit_count_o = lc_q;
  assign rd_row_o    = row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= iprle_pkg::PH_MAIN;
      rv_q          <= '0;
      rl_q          <= '0;
      lc_q          <= '0;
      row_q         <= '0;
      pos_q         <= '0;
      plane_q       <= 2'd0;
      prefix_done_q <= 1'b0;
    end else if (en) begin
      phase_q       <= phase_d;
      rv_q          <= rv_d;
      rl_q          <= rl_d;
      lc_q          <= lc_d;
      row_q         <= row_d;
      pos_q         <= pos_d;
      plane_q       <= plane_d;
      prefix_done_q <= prefix_done_d;
    end
  end

endmodule

// File: hdl/iprle_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprle_out_reg: result register
// Holds one result word until the consumer takes it; a new word loads in the
// same cycle the held one leaves.
// ----------------------------------------------------------------------------
module iprle_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  iprle_pkg::word_t word_i,
  input  logic             ready_i,
  output logic             can_load_o,
  output logic             valid_o,
  output iprle_pkg::word_t word_o
);

  logic             valid_q;
  iprle_pkg::word_t word_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign word_o     = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

endmodule

// File: hdl/icon_plane_rle_encoder_unit.sv
// ----------------------------------------------------------------------------
// icon_plane_rle_encoder_unit: run-length encoder for icon color planes
// The first result word of a byte passes the input register, then the result
// register. Throughput: one byte per cycle while the port takes each word and
// each byte yields at most one word, splits no literal pair and ends no plane;
// otherwise the byte stays in the input register for each further word or step.
// Reset: all control state clears at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The host streams the red plane, then green, then blue, one byte per
// transfer. Each byte lands in an input register; a sequencer behind it
// extends the open run or closes it, either into a repeat group or into the
// pending literal block, and writes at most one result word per cycle into
// the output register. The literal block is stored as rows of eight bytes so
// that each flush word is a single row read with the header patched in.
// The input register frees up in the same cycle its byte completes, so a new
// transfer is taken while the output register still holds an earlier word.
module icon_plane_rle_encoder_unit #(
  parameter int MaxPixels  = iprle_pkg::MaxPixelsDef,
  parameter int MaxLiteral = iprle_pkg::MaxLiteralDef,
  parameter int MaxRun     = iprle_pkg::MaxRunDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [iprle_pkg::CfgDataW-1:0]    cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        sample_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [iprle_pkg::DataW-1:0]       data_o,
  output logic [iprle_pkg::CountW-1:0]      byte_count_o,
  output logic                              end_of_plane_o,
  output logic                              end_of_image_o,
  output logic                              last_of_item_o
);

  localparam int LcW  = $clog2(MaxLiteral + 1);
  localparam int Rows = (MaxLiteral + 8) / 8;
  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;

  // Configuration registers.
  logic [iprle_pkg::PixelCountW-1:0] pixel_count_q;
  logic                              prefix_enable_q;

  // Input register.
  logic       item_valid_q;
  logic [7:0] sample_q;
  logic       item_done;
  logic       in_xfer;

  // Sequencer to store and output register.
  logic                              emit;
  logic                              can_emit;
  iprle_pkg::word_t                  emit_word;
  iprle_pkg::word_t                  out_word;
  logic [1:0]                        app_cnt;
  logic [7:0]                        app_value;
  logic [LcW-1:0]                    lit_count;
  logic [RowW-1:0]                   rd_row;
  logic [iprle_pkg::DataW-1:0]       rd_data;
  logic [iprle_pkg::CountW-1:0]      rd_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q   <= iprle_pkg::PixelCountW'(1);
      prefix_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        iprle_pkg::CfgPixelCount: begin
          pixel_count_q <= cfg_data_i;
        end
        iprle_pkg::CfgPrefixEnable: begin
          prefix_enable_q <= cfg_data_i[0];
        end
        default: begin
          prefix_enable_q <= prefix_enable_q;
        end
      endcase
    end
  end

  // The held byte is replaced in the cycle it completes.
  assign in_ready_o = !item_valid_q || item_done;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_xfer) begin
      item_valid_q <= 1'b1;
    end else if (item_done) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= sample_i;
    end
  end

  iprle_ctrl #(
    .MaxPixels  (MaxPixels),
    .MaxLiteral (MaxLiteral),
    .MaxRun     (MaxRun)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid_q),
    .sample_i        (sample_q),
    .pixel_count_i   (pixel_count_q),
    .prefix_enable_i (prefix_enable_q),
    .can_emit_i      (can_emit),
    .item_done_o     (item_done),
    .emit_o          (emit),
    .word_o          (emit_word),
    .app_cnt_o       (app_cnt),
    .app_value_o     (app_value),
    .lit_count_o     (lit_count),
    .rd_row_o        (rd_row),
    .rd_data_i       (rd_data),
    .rd_count_i      (rd_count)
  );

  iprle_lit_buf #(
    .MaxLiteral (MaxLiteral)
  ) u_lit_buf (
    .clk_i       (clk_i),
    .app_cnt_i   (app_cnt),
    .app_value_i (app_value),
    .lit_count_i (lit_count),
    .rd_row_i    (rd_row),
    .rd_data_o   (rd_data),
    .rd_count_o  (rd_count)
  );

  iprle_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (emit),
    .word_i     (emit_word),
    .ready_i    (out_ready_i),
    .can_load_o (can_emit),
    .valid_o    (out_valid_o),
    .word_o     (out_word)
  );

  assign data_o         = out_word.data;
  assign byte_count_o   = out_word.byte_count;
  assign end_of_plane_o = out_word.end_of_plane;
  assign end_of_image_o = out_word.end_of_image;
  assign last_of_item_o = out_word.last_of_item;

endmodule

// File: tb/icon_plane_rle_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icon_plane_rle_encoder_unit_tb: self-checking bench for the plane encoder
// Streams color-plane bytes into the encoder under random back-pressure,
// predicts every result word with a behavioral encoder and compares each
// word field by field. A short directed table comes first, then one long plane
// with a size change mid-plane, then short random images of runs and literals.
// ----------------------------------------------------------------------------

module icon_plane_rle_encoder_unit_tb;

  localparam int ResultCap   = 20;    // most words a single byte can produce
  localparam int SettleTicks = 8;     // quiet cycles before a register write
  localparam int QuietLimit  = 2000;  // cycles without any transfer
  localparam int RandomBytes = 160;   // bytes in the short random images
  localparam int ReportCap   = 40;    // mismatch lines printed at most

  typedef enum logic { ROW_REG, ROW_BYTE } row_kind_e;

  // One line of the directed table: either a register write or a byte,
  // the latter with an optional hand-written expected word.
  typedef struct packed {
    row_kind_e        kind;
    logic             reg_index;
    logic [14:0]      reg_value;
    logic [7:0]       sample;
    logic             known;
    iprle_pkg::word_t want;
  } stim_row_t;

  // Clock, reset and block inputs, all known from time zero.
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic        cfg_index_i  = 1'b0;
  logic [14:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  sample_i     = '0;
  logic        out_ready_i  = 1'b0;

  logic                               in_ready_o;
  logic                               out_valid_o;
  logic [iprle_pkg::DataW-1:0]        data_o;
  logic [iprle_pkg::CountW-1:0]       byte_count_o;
  logic                               end_of_plane_o;
  logic                               end_of_image_o;
  logic                               last_of_item_o;

  // Travel with the byte on the input channel; a known row replaces the
  // predicted words of that byte by the word typed into the table.
  logic             known_q = 1'b0;
  iprle_pkg::word_t known_word_q = '0;

  // Behavioral encoder state and its copy of the two registers.
  logic [14:0] pixel_limit;
  logic        prefix_on;
  logic [7:0]  run_byte;
  logic [7:0]  run_len;
  logic [7:0]  lit_buf [0:127];
  logic [7:0]  lit_len;
  logic [13:0] pixel_pos;
  logic [1:0]  plane_idx;
  logic        prefix_sent;
  logic [7:0]  group_buf [0:128];

  iprle_pkg::word_t byte_words[$];     // words produced by the current byte
  iprle_pkg::word_t pending_words[$];  // words still owed by the block
  iprle_pkg::word_t head_word;

  stim_row_t   plan[$];
  int          mismatches   = 0;
  int          words_seen   = 0;
  int          quiet_cycles = 0;
  int          stall_left   = 0;
  bit          calm         = 1'b0;   // no idling on either side while set
  logic [7:0]  gen_val      = '0;
  int          gen_left     = 0;

  icon_plane_rle_encoder_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_o         (data_o),
    .byte_count_o   (byte_count_o),
    .end_of_plane_o (end_of_plane_o),
    .end_of_image_o (end_of_image_o),
    .last_of_item_o (last_of_item_o)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Behavioral encoder
  // --------------------------------------------------------------------------

  // A byte never yields more than the cap; anything past it is dropped.
  function automatic void emit_word(logic [63:0] d, int cnt);
    iprle_pkg::word_t w;
    if (byte_words.size() < ResultCap) begin
      w = '0;
      w.data = d;
      w.byte_count = 4'(cnt);
      byte_words.push_back(w);
    end
  endfunction

  // Packs a code group from group_buf into words, first byte lowest.
  function automatic void emit_group(int len);
    logic [63:0] d;
    int off;
    int k;
    int j;
    for (off = 0; off < len; off += int'(iprle_pkg::WordBytes)) begin
      d = '0;
      k = len - off;
      if (k > int'(iprle_pkg::WordBytes)) k = int'(iprle_pkg::WordBytes);
      for (j = 0; j < k; j++) d[8*j +: 8] = group_buf[off + j];
      emit_word(d, k);
    end
  endfunction

  function automatic void flush_literals();
    int i;
    if (lit_len != 0) begin
      group_buf[0] = {1'b0, 7'(lit_len - 8'd1)};
      for (i = 0; i < int'(lit_len); i++) group_buf[i + 1] = lit_buf[i];
      emit_group(int'(lit_len) + 1);
      lit_len = '0;
    end
  endfunction

  // A full block goes out before the next byte joins, so a pair can split.
  function automatic void add_literal(logic [7:0] v);
    if (lit_len >= 8'(iprle_pkg::MaxLiteralDef)) flush_literals();
    lit_buf[lit_len[6:0]] = v;
    lit_len = lit_len + 8'd1;
  endfunction

  // Long runs become a repeat group; one or two bytes join the literal block.
  function automatic void close_run();
    int i;
    if (run_len >= 8'(iprle_pkg::RunMin)) begin
      flush_literals();
      group_buf[0] = iprle_pkg::RunFlag | {1'b0, 7'(run_len - 8'(iprle_pkg::RunMin))};
      group_buf[1] = run_byte;
      emit_group(2);
    end else begin
      for (i = 0; i < int'(run_len); i++) add_literal(run_byte);
    end
    run_len = '0;
  endfunction

  // Works out every word that one byte causes and leaves them in byte_words.
  function automatic void encode_sample(logic [7:0] s);
    int               limit;
    bit               blue;
    iprle_pkg::word_t w;
    byte_words.delete();
    limit = int'(pixel_limit);
    if (limit < 1) limit = 1;
    if (limit > iprle_pkg::MaxPixelsDef) limit = iprle_pkg::MaxPixelsDef;

    if (!prefix_sent) begin
      if (prefix_on) emit_word('0, int'(iprle_pkg::PrefixBytes));
      prefix_sent = 1'b1;
    end

    if (run_len != 0 && s == run_byte && run_len < 8'(iprle_pkg::MaxRunDef)) begin
      run_len = run_len + 8'd1;
    end else begin
      close_run();
      run_byte = s;
      run_len = 8'd1;
    end

    // Plane end: close the open run, send the pending block, tag the last word.
    if (int'(pixel_pos) + 1 >= limit) begin
      blue = (plane_idx >= 2'd2);
      close_run();
      flush_literals();
      if (byte_words.size() > 0) begin
        w = byte_words.pop_back();
        w.end_of_plane = 1'b1;
        w.end_of_image = blue;
        byte_words.push_back(w);
      end
      pixel_pos = '0;
      if (blue) begin
        plane_idx = '0;
        prefix_sent = 1'b0;
      end else begin
        plane_idx = plane_idx + 2'd1;
      end
    end else begin
      pixel_pos = pixel_pos + 14'd1;
    end

    if (byte_words.size() > 0) begin
      w = byte_words.pop_back();
      w.last_of_item = 1'b1;
      byte_words.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: results are checked before the byte of the same edge is
  // predicted, since a word leaving now cannot stem from a byte arriving now.
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= ReportCap)
      $display("tb: word %0d %s mismatch: got %h, expected %h",
               words_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected", data_o, '0);
        end else begin
          head_word = pending_words.pop_front();
          if (data_o !== head_word.data)
            report_mismatch("data", data_o, head_word.data);
          if (byte_count_o !== head_word.byte_count)
            report_mismatch("byte_count", 64'(byte_count_o), 64'(head_word.byte_count));
          if (end_of_plane_o !== head_word.end_of_plane)
            report_mismatch("end_of_plane", 64'(end_of_plane_o), 64'(head_word.end_of_plane));
          if (end_of_image_o !== head_word.end_of_image)
            report_mismatch("end_of_image", 64'(end_of_image_o), 64'(head_word.end_of_image));
          if (last_of_item_o !== head_word.last_of_item)
            report_mismatch("last_of_item", 64'(last_of_item_o), 64'(head_word.last_of_item));
        end
        words_seen++;
      end

      if (cfg_we_i) begin
        if (cfg_index_i == iprle_pkg::CfgPixelCount) pixel_limit = cfg_data_i;
        else if (cfg_index_i == iprle_pkg::CfgPrefixEnable) prefix_on = cfg_data_i[0];
      end

      if (in_valid_i && in_ready_o) begin
        encode_sample(sample_i);
        if (known_q) begin
          pending_words.push_back(known_word_q);
        end else begin
          foreach (byte_words[i]) pending_words.push_back(byte_words[i]);
        end
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: ready drops in random bursts unless calm.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left  <= $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offers one byte, sometimes after a gap, and returns at its transfer.
  // Valid is left high so that a following byte keeps it high without a dip.
  task automatic send_byte(input logic [7:0] s, input logic known,
                           input iprle_pkg::word_t want);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_i     <= s;
    known_q      <= known;
    known_word_q <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Registers change only once every owed word is out and the block is quiet.
  task automatic write_reg(input logic idx, input logic [14:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Short runs and lone bytes with some noise; a new run changes value unless forced to 00 or FF.
  function automatic logic [7:0] pick_sample();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    if (gen_left == 0) begin
      gen_val = gen_val + 8'($urandom_range(1, 255));
      if ($urandom_range(0, 7) == 0) gen_val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      gen_left = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 7) : 1;
    end
    gen_left--;
    return gen_val;
  endfunction

  function automatic stim_row_t reg_row(logic idx, logic [14:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_index = idx;
    r.reg_value = value;
    return r;
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] s);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.sample = s;
    return r;
  endfunction

  // A byte whose single word is obvious: a literal block or a closing run.
  function automatic stim_row_t known_row(logic [7:0] s, logic [63:0] d,
                                          logic [3:0] cnt, logic eop, logic eoi);
    stim_row_t r;
    r = byte_row(s);
    r.known = 1'b1;
    r.want.data = d;
    r.want.byte_count = cnt;
    r.want.end_of_plane = eop;
    r.want.end_of_image = eoi;
    r.want.last_of_item = 1'b1;
    return r;
  endfunction

  initial begin
    logic [7:0]  v;
    logic [14:0] limit_now;
    int          per_phase;
    int          sent;

    pixel_limit = 15'd1;
    prefix_on   = 1'b0;
    run_byte    = '0;
    run_len     = '0;
    lit_len     = '0;
    pixel_pos   = '0;
    plane_idx   = '0;
    prefix_sent = 1'b0;

    // Reset defaults: one pixel per plane, so each byte is a one-byte
    // literal block that closes its plane.
    plan.push_back(known_row(8'h00, 64'h0000, 4'd2, 1'b1, 1'b0));
    plan.push_back(known_row(8'hFF, 64'hFF00, 4'd2, 1'b1, 1'b0));
    plan.push_back(known_row(8'h5A, 64'h5A00, 4'd2, 1'b1, 1'b1));
    // Prefix word ahead of the first byte of the next image only.
    plan.push_back(reg_row(iprle_pkg::CfgPrefixEnable, 15'd1));
    plan.push_back(byte_row(8'h80));
    plan.push_back(known_row(8'h01, 64'h0100, 4'd2, 1'b1, 1'b0));
    plan.push_back(known_row(8'h7F, 64'h7F00, 4'd2, 1'b1, 1'b1));
    // A pixel count of zero behaves as one.
    plan.push_back(reg_row(iprle_pkg::CfgPixelCount, 15'd0));
    plan.push_back(byte_row(8'hAA));
    plan.push_back(byte_row(8'h55));
    plan.push_back(byte_row(8'h3C));
    // Six equal bytes make one repeat group at plane end.
    plan.push_back(reg_row(iprle_pkg::CfgPrefixEnable, 15'd0));
    plan.push_back(reg_row(iprle_pkg::CfgPixelCount, 15'd6));
    repeat (5) plan.push_back(byte_row(8'h07));
    plan.push_back(known_row(8'h07, 64'h0783, 4'd2, 1'b1, 1'b0));
    // Literal block flushed ahead of a closing run of three.
    plan.push_back(byte_row(8'h01));
    plan.push_back(byte_row(8'h02));
    plan.push_back(byte_row(8'h02));
    plan.push_back(byte_row(8'h03));
    plan.push_back(byte_row(8'h03));
    plan.push_back(byte_row(8'h03));
    // Largest register value, then shrunk mid-plane: the next byte ends it.
    plan.push_back(reg_row(iprle_pkg::CfgPixelCount, 15'h7FFF));
    plan.push_back(byte_row(8'hC3));
    plan.push_back(byte_row(8'hC3));
    plan.push_back(reg_row(iprle_pkg::CfgPixelCount, 15'd1));
    plan.push_back(known_row(8'hC3, 64'hC380, 4'd2, 1'b1, 1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].reg_index, plan[i].reg_value);
      else send_byte(plan[i].sample, plan[i].known, plan[i].want);
    end

    // One long plane: a run past the longest repeat, then a literal stretch
    // that fills a block so that a following pair splits across two blocks.
    write_reg(iprle_pkg::CfgPrefixEnable, 15'($urandom_range(0, 1)));
    write_reg(iprle_pkg::CfgPixelCount, 15'(iprle_pkg::MaxPixelsDef));
    v = 8'($urandom_range(0, 255));
    repeat (iprle_pkg::MaxRunDef + 1) send_byte(v, 1'b0, '0);
    repeat (iprle_pkg::MaxLiteralDef - 2) begin
      v = v + 8'($urandom_range(1, 255));
      send_byte(v, 1'b0, '0);
    end
    v = v + 8'($urandom_range(1, 255));
    send_byte(v, 1'b0, '0);
    send_byte(v, 1'b0, '0);
    v = v + 8'($urandom_range(1, 255));
    send_byte(v, 1'b0, '0);
    write_reg(iprle_pkg::CfgPixelCount, 15'd2);
    send_byte(8'($urandom_range(0, 255)), 1'b0, '0);

    // Short random images; the final stretch runs with no idling at all.
    sent = 0;
    while (sent < RandomBytes) begin
      calm = (sent >= RandomBytes - 40) || ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1)
        write_reg(iprle_pkg::CfgPrefixEnable, 15'($urandom_range(0, 1)));
      limit_now = ($urandom_range(0, 5) == 0) ? 15'($urandom_range(0, 24))
                                              : 15'($urandom_range(1, 8));
      write_reg(iprle_pkg::CfgPixelCount, limit_now);
      per_phase = 3 * ((limit_now == 0) ? 1 : int'(limit_now));
      repeat (per_phase) begin
        send_byte(pick_sample(), 1'b0, '0);
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
